### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// clock edge and is switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent on one edge implies the consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/phs_pkg.sv
package phs_pkg;

	localparam int MAX_PROFILES = 8;
	localparam int IDX_W = 3;
	localparam int CNT_W = 4;
	localparam int MODE_W = 2;
	localparam int PERIOD_W = 32;
	localparam int ADDR_W = 2;

	// Hardware never holds more than eight profiles, whatever the table size.
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'((MAX_PROFILES < 8) ? MAX_PROFILES : 8);

	localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CYCLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

	localparam logic [ADDR_W-1:0] REG_COUNT = 2'd0;
	localparam logic [ADDR_W-1:0] REG_MODE = 2'd1;
	localparam logic [ADDR_W-1:0] REG_PERIOD = 2'd2;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SELECT = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic down;
		logic [PERIOD_W-1:0] elapsed;
	} seq_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic hopped;
		logic rejected;
	} hop_result_t;

	// A count of zero behaves as one; large counts are capped.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (r == '0) r = CNT_W'(1);
		if (r > COUNT_CAP) r = COUNT_CAP;
		return r;
	endfunction

endpackage

### sv/profile_hop_sequencer_unit.sv
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   select_index[2:0], zero pad to 8 bits       action
// m_axis   out  active_profile[2:0], hopped, select_rejected, pad  none
// cfg      in   cfg_addr selects count/mode/period, data in cfg_wdata
//
// One request per cycle sustained while m_tready stays high; each request is
// held in the input register and its result is then loaded into the output
// register, which drives m_tvalid.
// The index/tick update is a single pass of logic between those registers.
// Reset (arst_n low) clears the state and sets count 1, manual mode, period 0.
// A stalled output holds the input register; s_tready drops only then.
module profile_hop_sequencer_unit
	import phs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,   // [2:0] select_index, [7:3] zero
	input logic s_tuser,         // [0] action
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,  // [2:0] active_profile, [3] hopped, [4] select_rejected
	input logic cfg_we,
	input logic [ADDR_W-1:0] cfg_addr,
	input logic [PERIOD_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0] count_q;
	logic [MODE_W-1:0] mode_q;
	logic [PERIOD_W-1:0] period_q;
	seq_state_t st_q;

	logic valid_s1;
	logic action_s1;
	logic [IDX_W-1:0] sel_s1;

	logic out_valid_q;
	hop_result_t out_s2;

	seq_state_t st_nxt;
	hop_result_t res;
	logic adv_s1;
	logic acc_in;

	assign adv_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign acc_in = s_tvalid && s_tready;

	phs_next u_next (
		.st(st_q),
		.count(count_q),
		.mode(mode_q),
		.period(period_q),
		.action(action_s1),
		.sel(sel_s1),
		.nxt(st_nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			action_s1 <= s_tuser;
			sel_s1 <= s_tdata[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) out_s2 <= res;
	end

	// Configuration must only arrive while no request is in flight; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			mode_q <= MODE_MANUAL;
			period_q <= '0;
			st_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COUNT: begin
					count_q <= cfg_wdata[CNT_W-1:0];
					st_q <= '0;
				end
				REG_MODE: begin
					mode_q <= cfg_wdata[MODE_W-1:0];
					st_q.elapsed <= '0;
				end
				REG_PERIOD: begin
					period_q <= cfg_wdata;
					st_q.elapsed <= '0;
				end
				default: begin
				end
			endcase
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_s2.rejected, out_s2.hopped, out_s2.idx};

`include "assert_macros.svh"

	`ASSERT_CLK(a_idx_in_range, CNT_W'(st_q.idx) < eff_count(count_q), "index beyond profile count")
	`ASSERT_CLK(a_flags_exclusive, !(out_valid_q && out_s2.hopped && out_s2.rejected), "hop and reject together")
	`ASSERT_NEXT(a_reject_holds, adv_s1 && !cfg_we && res.rejected, st_q == $past(st_q), "rejected select changed state")

endmodule

### sv/phs_next.sv
module phs_next
	import phs_pkg::*;
(
	input seq_state_t st,
	input logic [CNT_W-1:0] count,
	input logic [MODE_W-1:0] mode,
	input logic [PERIOD_W-1:0] period,
	input logic action,
	input logic [IDX_W-1:0] sel,
	output seq_state_t nxt,
	output hop_result_t res
);

	logic [CNT_W-1:0] c;
	logic [CNT_W-1:0] i;
	logic [CNT_W-1:0] i_inc;
	logic [PERIOD_W:0] e;
	logic active;

	always_comb begin
		c = eff_count(count);
		i = CNT_W'(st.idx);
		if (i >= c) i = c - CNT_W'(1);
		i_inc = i + CNT_W'(1);
		e = {1'b0, st.elapsed} + (PERIOD_W+1)'(1);
		active = ((mode == MODE_CYCLE) || (mode == MODE_PINGPONG)) && (period != '0);

		nxt = st;
		res = '0;

		if (action == ACT_SELECT) begin
			if (CNT_W'(sel) < c) nxt.idx = sel;
			else res.rejected = 1'b1;
		end else if (active) begin
			if (e >= {1'b0, period}) begin
				nxt.elapsed = '0;
				res.hopped = 1'b1;
				case (mode)
					MODE_CYCLE: begin
						nxt.idx = (i_inc >= c) ? '0 : i_inc[IDX_W-1:0];
					end
					MODE_PINGPONG: begin
						if (c < CNT_W'(2)) begin
							nxt.idx = '0;
							nxt.down = 1'b0;
						end else if (!st.down) begin
							if (i_inc >= c) begin
								nxt.idx = IDX_W'(c - CNT_W'(2));
								nxt.down = 1'b1;
							end else begin
								nxt.idx = i_inc[IDX_W-1:0];
							end
						end else begin
							if (i == '0) begin
								nxt.idx = IDX_W'(1);
								nxt.down = 1'b0;
							end else begin
								nxt.idx = IDX_W'(i - CNT_W'(1));
							end
						end
					end
					default: begin
						nxt.idx = i[IDX_W-1:0];
					end
				endcase
			end else begin
				nxt.elapsed = e[PERIOD_W-1:0];
			end
		end

		res.idx = nxt.idx;
	end

endmodule
